// ===== hw/rtl/srsm_pkg.sv =====
// Shared types and codes for the sorted row-set merge block.
// Used by srsm_ctrl, srsm_dp, sorted_row_set_merge and tb; depends on nothing.
`default_nettype none

package srsm_pkg;

	// input item kind, carried on s_tuser
	typedef enum logic [1:0] {
		MODE_LOAD_FIRST  = 2'd0,
		MODE_LOAD_SECOND = 2'd1,
		MODE_PULL        = 2'd2,
		MODE_CLEAR       = 2'd3
	} mode_t;

	// set operation register codes; codes above complement mean no result
	typedef enum logic [2:0] {
		OP_INTERSECT  = 3'd0,
		OP_UNION      = 3'd1,
		OP_DIFFERENCE = 3'd2,
		OP_SYMM_DIFF  = 3'd3,
		OP_COMPLEMENT = 3'd4
	} set_op_t;

	// configuration register indexes
	typedef enum logic {
		REG_SET_OPERATION = 1'b0,
		REG_UNIVERSE_ROWS = 1'b1
	} reg_idx_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL
	} state_t;

	localparam int unsigned RESULT_W = 32;
	localparam logic [RESULT_W-1:0] ROW_MAX = 32'hffff_ffff;

	// commands from controller to datapath
	typedef struct packed {
		logic load_first;
		logic load_second;
		logic clear;
		logic step;      // commit pointer and candidate updates of this evaluation
		logic out_load;  // capture the result into the output register
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hit;       // evaluation gives a result or finds the set exhausted
		logic ptr_ok;    // both read pointers within their counts
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srsm_ctrl.sv =====
// Controller state machine of the sorted row-set merge block.
// Depends on srsm_pkg; drives the datapath srsm_dp through dp_cmd_t.
`default_nettype none

module srsm_ctrl
	import srsm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire logic [1:0] in_mode,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode_t'(in_mode))
						MODE_LOAD_FIRST:  cmd.load_first  = 1'b1;
						MODE_LOAD_SECOND: cmd.load_second = 1'b1;
						MODE_CLEAR:       cmd.clear       = 1'b1;
						MODE_PULL:        state_d         = ST_FETCH;
						default:          state_d         = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!sts.hit) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					cmd.step     = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srsm_dp.sv =====
// Datapath of the sorted row-set merge block: list stores, counts, pointers,
// merge decision, configuration and output registers. Depends on srsm_pkg.
`default_nettype none

module srsm_dp
	import srsm_pkg::*;
#(
	parameter int unsigned LIST_DEPTH = 1024,
	parameter int unsigned ROW_WIDTH  = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts,
	input  wire logic [RESULT_W-1:0] row_in,
	input  wire logic                cfg_we,
	input  wire logic                cfg_addr,
	input  wire logic [RESULT_W-1:0] cfg_wdata,
	output logic [ROW_WIDTH-1:0]     res_row,
	output logic                     res_valid,
	output logic [RESULT_W-1:0]      res_position,
	output logic                     res_overflowed
);

	localparam int unsigned AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

	// list stores
	logic [ROW_WIDTH-1:0] first_mem  [LIST_DEPTH];
	logic [ROW_WIDTH-1:0] second_mem [LIST_DEPTH];
	logic [ROW_WIDTH-1:0] a_s1, b_s1;

	logic [CNT_W-1:0]    cnt1_q, cnt2_q, rp1_q, rp2_q, rp1_nxt, rp2_nxt;
	logic [RESULT_W-1:0] cn_q, emitted_q, universe_q;
	logic [2:0]          op_q;
	logic                ovf_q;

	logic                h1, h2;
	logic [RESULT_W-1:0] a_ext;
	logic                adv1, adv2, emit, done, cn_we;
	logic [RESULT_W-1:0] cn_d;
	logic [ROW_WIDTH-1:0] row_d;
	logic                full1, full2;

	assign full1 = (cnt1_q == FULL);
	assign full2 = (cnt2_q == FULL);
	assign h1    = (rp1_q < cnt1_q);
	assign h2    = (rp2_q < cnt2_q);
	assign a_ext = RESULT_W'(a_s1);

	assign sts.hit    = emit || done;
	assign sts.ptr_ok = (rp1_q <= cnt1_q) && (rp2_q <= cnt2_q);

	// read pointers as they stand after this cycle's commit
	assign rp1_nxt = rp1_q + CNT_W'(cmd.step && adv1);
	assign rp2_nxt = rp2_q + CNT_W'(cmd.step && adv2);

	// store write ports
	always_ff @(posedge clk) begin
		if (cmd.load_first && !full1) begin
			first_mem[cnt1_q[AW-1:0]] <= row_in[ROW_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_second && !full2) begin
			second_mem[cnt2_q[AW-1:0]] <= row_in[ROW_WIDTH-1:0];
		end
	end

	// registered head reads
	always_ff @(posedge clk) begin
		a_s1 <= first_mem[rp1_nxt[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		b_s1 <= second_mem[rp2_nxt[AW-1:0]];
	end

	// merge decision on the current list heads
	always_comb begin
		adv1  = 1'b0;
		adv2  = 1'b0;
		emit  = 1'b0;
		done  = 1'b0;
		cn_we = 1'b0;
		cn_d  = cn_q;
		row_d = a_s1;
		case (op_q) inside
			OP_INTERSECT: begin
				if (!h1 || !h2) begin
					done = 1'b1;
				end else if (a_s1 == b_s1) begin
					emit = 1'b1;
					adv1 = 1'b1;
					adv2 = 1'b1;
				end else if (a_s1 < b_s1) begin
					adv1 = 1'b1;
				end else begin
					adv2 = 1'b1;
				end
			end
			OP_UNION, OP_SYMM_DIFF: begin
				if (h1 && h2) begin
					if (a_s1 == b_s1) begin
						adv1 = 1'b1;
						adv2 = 1'b1;
						emit = (op_q == OP_UNION);
					end else if (a_s1 < b_s1) begin
						emit = 1'b1;
						adv1 = 1'b1;
					end else begin
						emit  = 1'b1;
						adv2  = 1'b1;
						row_d = b_s1;
					end
				end else if (h1) begin
					emit = 1'b1;
					adv1 = 1'b1;
				end else if (h2) begin
					emit  = 1'b1;
					adv2  = 1'b1;
					row_d = b_s1;
				end else begin
					done = 1'b1;
				end
			end
			OP_DIFFERENCE: begin
				if (!h1) begin
					done = 1'b1;
				end else if (h2 && a_s1 == b_s1) begin
					adv1 = 1'b1;
					adv2 = 1'b1;
				end else if (h2 && a_s1 > b_s1) begin
					adv2 = 1'b1;
				end else begin
					emit = 1'b1;
					adv1 = 1'b1;
				end
			end
			OP_COMPLEMENT: begin
				row_d = cn_q[ROW_WIDTH-1:0];
				if (h1 && !(cn_q < a_ext && cn_q < universe_q)) begin
					// skip past this list entry, saturating at the top row
					adv1  = 1'b1;
					cn_we = 1'b1;
					cn_d  = (a_ext == ROW_MAX) ? ROW_MAX : a_ext + 1'b1;
				end else if (cn_q < universe_q) begin
					emit  = 1'b1;
					cn_we = 1'b1;
					cn_d  = cn_q + 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			default: done = 1'b1;
		endcase
	end

	// counts, pointers, candidate and result counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q    <= '0;
			cnt2_q    <= '0;
			rp1_q     <= '0;
			rp2_q     <= '0;
			cn_q      <= '0;
			emitted_q <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.clear) begin
			cnt1_q    <= '0;
			cnt2_q    <= '0;
			rp1_q     <= '0;
			rp2_q     <= '0;
			cn_q      <= '0;
			emitted_q <= '0;
		end else begin
			if (cmd.load_first) begin
				if (full1) ovf_q  <= 1'b1;
				else       cnt1_q <= cnt1_q + 1'b1;
			end
			if (cmd.load_second) begin
				if (full2) ovf_q  <= 1'b1;
				else       cnt2_q <= cnt2_q + 1'b1;
			end
			rp1_q <= rp1_nxt;
			rp2_q <= rp2_nxt;
			if (cmd.step && cn_we) cn_q <= cn_d;
			if (cmd.out_load && emit) emitted_q <= emitted_q + 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= '0;
			universe_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_SET_OPERATION: op_q       <= cfg_wdata[2:0];
				REG_UNIVERSE_ROWS: universe_q <= cfg_wdata;
				default:           op_q       <= op_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_row        <= emit ? row_d : '0;
			res_valid      <= emit;
			res_position   <= emitted_q;
			res_overflowed <= ovf_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_row_set_merge.sv =====
// Top level of the sorted row-set merge block.
// Instantiates srsm_ctrl and srsm_dp; depends on srsm_pkg.
//
// Two ascending row lists are loaded into two stores of LIST_DEPTH entries
// (s_tuser mode 0 and 1, row in s_tdata); each pull (mode 2) returns one beat
// with the next element of the set operation chosen in register 0, and a
// beat with result_valid low once the set is used up; mode 3 clears counts,
// pointers, the complement candidate and the result counter but keeps the
// sticky overflow flag. A pull result is captured after a fetch state that
// reads the two list heads and an evaluation state that evaluates them and
// repeats for every list entry passed over without a result (matching heads
// in symmetric difference or difference, unmatched heads in intersection,
// smaller second-list heads in difference, list entries in complement),
// since each evaluation step needs a registered read of the two list heads.
// The block takes no new item while a pull is being evaluated and takes the
// next one once it is back in idle after the result is captured, so pulls
// do not overlap; a finished result waits in the output register while
// loads go on, and a later pull holds in evaluation until that beat is
// taken. The lists are not checked for order.
`default_nettype none

module sorted_row_set_merge
	import srsm_pkg::*;
#(
	parameter int unsigned LIST_DEPTH = 1024,
	parameter int unsigned ROW_WIDTH  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] row_number
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [31:0] result_row, [63:32] result_position,
	                                    // [64] overflowed, [71:65] zero
	output logic             m_tuser,   // [0] result_valid
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	dp_cmd_t              cmd;
	dp_sts_t              sts;
	logic [ROW_WIDTH-1:0] res_row;
	logic                 res_valid;
	logic [RESULT_W-1:0]  res_position;
	logic                 res_overflowed;

	// controller
	srsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	srsm_dp #(
		.LIST_DEPTH (LIST_DEPTH),
		.ROW_WIDTH  (ROW_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.row_in         (s_tdata),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.res_row        (res_row),
		.res_valid      (res_valid),
		.res_position   (res_position),
		.res_overflowed (res_overflowed)
	);

	// result beat packing
	assign m_tdata = {7'd0, res_overflowed, res_position, RESULT_W'(res_row)};
	assign m_tuser = res_valid;

	// a result is captured only into a free or draining output register
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result captured over an untaken beat");

	// an exhausted beat carries row zero
	a_exhausted_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[31:0] == 32'd0))
		else $error("exhausted beat with nonzero row");

	// read pointers never pass their list counts
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ptr_ok)
		else $error("read pointer beyond list count");

	// a captured pull result is presented as a valid beat in the next cycle
	a_beat_follows_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("captured result not presented");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the sorted row-set merge block.
// Drives loads, pulls and clears as stream beats, predicts every result beat
// from its own model of the two list stores; depends on srsm_pkg and the RTL.
`default_nettype none

module tb;
	import srsm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_DEPTH     = 1024;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned HOLD_CYCLES    = 1500;
	// reserved operation codes, a pull answers with an exhausted beat
	localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

	typedef struct packed {
		logic [31:0] row;
		logic        valid;
		logic [31:0] position;
		logic        overflow;
	} merge_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = MODE_LOAD_FIRST;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = REG_SET_OPERATION;
	logic [31:0] cfg_wdata = '0;

	// predictor state
	logic [31:0] first_rows  [LIST_DEPTH];
	logic [31:0] second_rows [LIST_DEPTH];
	int unsigned first_fill = 0, second_fill = 0;
	int unsigned first_head = 0, second_head = 0;
	logic [31:0] gap_candidate = '0;
	logic [31:0] emitted = '0;
	logic        sticky_overflow = 1'b0;
	logic [2:0]  op_code = OP_INTERSECT;
	logic [31:0] universe = '0;

	merge_result_t pending_results[$];

	int errors = 0;
	int beats_in = 0, beats_out = 0, elements_out = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	int hold_left = 0;
	int unsigned quiet_cycles = 0;

	sorted_row_set_merge #(
		.LIST_DEPTH(LIST_DEPTH),
		.ROW_WIDTH (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// next element of the selected set operation, advancing the list heads
	function automatic bit merge_next(output logic [31:0] row);
		bit          h1, h2;
		logic [31:0] a, b;
		row = '0;
		while (1) begin
			h1 = first_head < first_fill;
			h2 = second_head < second_fill;
			a = h1 ? first_rows[first_head] : '0;
			b = h2 ? second_rows[second_head] : '0;
			case (op_code) inside
				OP_INTERSECT: begin
					if (!h1 || !h2)
						return 1'b0;
					if (a == b) begin
						row = a;
						first_head++;
						second_head++;
						return 1'b1;
					end
					if (a < b)
						first_head++;
					else
						second_head++;
				end
				OP_UNION, OP_SYMM_DIFF: begin
					if (h1 && h2 && a == b) begin
						first_head++;
						second_head++;
						if (op_code == OP_UNION) begin
							row = a;
							return 1'b1;
						end
					end else if (h1 && (!h2 || a < b)) begin
						row = a;
						first_head++;
						return 1'b1;
					end else if (h2) begin
						row = b;
						second_head++;
						return 1'b1;
					end else begin
						return 1'b0;
					end
				end
				OP_DIFFERENCE: begin
					if (!h1)
						return 1'b0;
					if (h2 && a == b) begin
						first_head++;
						second_head++;
					end else if (h2 && a > b) begin
						second_head++;
					end else begin
						row = a;
						first_head++;
						return 1'b1;
					end
				end
				OP_COMPLEMENT: begin
					if (h1) begin
						if (gap_candidate < a && gap_candidate < universe) begin
							row = gap_candidate;
							gap_candidate++;
							return 1'b1;
						end
						// list entry moves the candidate past itself, saturating at the top
						gap_candidate = (a == ROW_MAX) ? ROW_MAX : a + 32'd1;
						first_head++;
					end else if (gap_candidate < universe) begin
						row = gap_candidate;
						gap_candidate++;
						return 1'b1;
					end else begin
						return 1'b0;
					end
				end
				default: return 1'b0;
			endcase
		end
	endfunction

	// predictor update for one accepted input beat
	function automatic void apply_beat(mode_t mode, logic [31:0] row_in);
		merge_result_t res;
		logic [31:0]   row;
		bit            found;
		case (mode)
			MODE_LOAD_FIRST: begin
				if (first_fill < LIST_DEPTH)
					first_rows[first_fill++] = row_in;
				else
					sticky_overflow = 1'b1;
			end
			MODE_LOAD_SECOND: begin
				if (second_fill < LIST_DEPTH)
					second_rows[second_fill++] = row_in;
				else
					sticky_overflow = 1'b1;
			end
			MODE_CLEAR: begin
				first_fill = 0;
				second_fill = 0;
				first_head = 0;
				second_head = 0;
				gap_candidate = '0;
				emitted = '0;
			end
			default: begin
				found = merge_next(row);
				res.row = found ? row : '0;
				res.valid = found;
				res.position = emitted;
				res.overflow = sticky_overflow;
				pending_results.push_back(res);
				if (found)
					emitted++;
			end
		endcase
	endfunction

	// send one input beat, idling cycle by cycle at the sender rate before it
	task automatic send_item(mode_t mode, logic [31:0] row_in);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= row_in;
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		apply_beat(mode, row_in);
		beats_in++;
		@(negedge clk);
	endtask

	// stop offering, wait for all results, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only ever issued on an idle block
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		if (idx == REG_SET_OPERATION)
			op_code = value[2:0];
		else
			universe = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// result beat checker
	always @(posedge clk) begin
		merge_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h user %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (exp_res.valid)
					elements_out++;
				check_field("result_row", exp_res.row, m_tdata[31:0]);
				check_field("result_position", exp_res.position, m_tdata[63:32]);
				check_field("overflowed", {31'd0, exp_res.overflow}, {31'd0, m_tdata[64]});
				check_field("padding", '0, {25'd0, m_tdata[71:65]});
				check_field("result_valid", {31'd0, exp_res.valid}, {31'd0, m_tuser});
			end
		end
	end

	// receiver ready, with random stalls and a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// every operation, row extremes, reserved codes, unsorted and late loads
	task automatic test_directed();
		write_reg(REG_SET_OPERATION, OP_UNION);
		send_item(MODE_LOAD_FIRST, 32'd0);
		send_item(MODE_LOAD_FIRST, ROW_MAX);
		send_item(MODE_LOAD_SECOND, ROW_MAX);
		repeat (3) send_item(MODE_PULL, '0);
		// complement candidate saturates past the top row
		write_reg(REG_SET_OPERATION, OP_COMPLEMENT);
		write_reg(REG_UNIVERSE_ROWS, 32'd3);
		send_item(MODE_CLEAR, '0);
		send_item(MODE_LOAD_FIRST, 32'd1);
		send_item(MODE_LOAD_FIRST, ROW_MAX);
		repeat (4) send_item(MODE_PULL, '0);
		write_reg(REG_UNIVERSE_ROWS, ROW_MAX);
		send_item(MODE_CLEAR, '0);
		repeat (2) send_item(MODE_PULL, '0);
		// unsorted first list, load after pulls
		write_reg(REG_SET_OPERATION, OP_SYMM_DIFF);
		send_item(MODE_CLEAR, '0);
		send_item(MODE_LOAD_FIRST, 32'd9);
		send_item(MODE_LOAD_FIRST, 32'd3);
		send_item(MODE_LOAD_SECOND, 32'd3);
		repeat (2) send_item(MODE_PULL, '0);
		send_item(MODE_LOAD_SECOND, 32'd4);
		repeat (2) send_item(MODE_PULL, '0);
		write_reg(REG_SET_OPERATION, OP_INTERSECT);
		send_item(MODE_PULL, '0);
		write_reg(REG_SET_OPERATION, OP_DIFFERENCE);
		send_item(MODE_PULL, '0);
		write_reg(REG_SET_OPERATION, OP_RESERVED_FIRST);
		send_item(MODE_PULL, '0);
		write_reg(REG_SET_OPERATION, OP_RESERVED_LAST);
		send_item(MODE_PULL, '0);
		// empty universe
		write_reg(REG_SET_OPERATION, OP_COMPLEMENT);
		write_reg(REG_UNIVERSE_ROWS, 32'd0);
		send_item(MODE_CLEAR, '0);
		send_item(MODE_PULL, '0);
	endtask

	// random load-then-pull sequences with some noise mixed in
	task automatic test_random(int sender_pct, int receiver_pct, int target);
		int          stop_at;
		int          n1, n2, r1, r2, pulls;
		bit          unsorted;
		logic [31:0] base, v1, v2, next_row, uni;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		stop_at = beats_in + target;
		while (beats_in < stop_at) begin
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_SET_OPERATION, $urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
			else
				write_reg(REG_SET_OPERATION, $urandom_range(OP_INTERSECT, OP_COMPLEMENT));
			case ($urandom_range(0, 3))
				0: base = '0;
				1: base = $urandom_range(0, 1000);
				2: base = $urandom;
				default: base = ROW_MAX - $urandom_range(0, 60);
			endcase
			if (op_code == OP_COMPLEMENT || $urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 5))
					0: uni = '0;
					1: uni = ROW_MAX;
					2: uni = $urandom;
					3: uni = base + $urandom_range(0, 80);
					default: uni = $urandom_range(0, 80);
				endcase
				write_reg(REG_UNIVERSE_ROWS, uni);
			end
			// now and then keep the old lists and pointers
			if ($urandom_range(0, 19) != 0)
				send_item(MODE_CLEAR, '0);
			unsorted = ($urandom_range(0, 9) == 0);
			n1 = $urandom_range(0, 12);
			n2 = $urandom_range(0, 12);
			r1 = n1;
			r2 = n2;
			v1 = base;
			v2 = base;
			while (r1 > 0 || r2 > 0) begin
				if (r1 > 0 && (r2 == 0 || $urandom_range(0, 1))) begin
					next_row = unsorted ? base + $urandom_range(0, 40) : v1;
					v1 = (v1 > ROW_MAX - 3) ? ROW_MAX : v1 + $urandom_range(0, 3);
					send_item(MODE_LOAD_FIRST, next_row);
					r1--;
				end else begin
					next_row = unsorted ? base + $urandom_range(0, 40) : v2;
					v2 = (v2 > ROW_MAX - 3) ? ROW_MAX : v2 + $urandom_range(0, 3);
					send_item(MODE_LOAD_SECOND, next_row);
					r2--;
				end
			end
			pulls = n1 + n2 + $urandom_range(1, 6);
			repeat (pulls) begin
				case ($urandom_range(0, 49))
					0: send_item(MODE_CLEAR, '0);
					1: send_item(MODE_LOAD_FIRST, base + $urandom_range(0, 40));
					2: send_item(MODE_LOAD_SECOND, base + $urandom_range(0, 40));
					default: ;
				endcase
				send_item(MODE_PULL, '0);
			end
		end
	endtask

	// receiver holds off while pulls and loads keep coming
	task automatic test_backpressure();
		write_reg(REG_SET_OPERATION, OP_UNION);
		send_item(MODE_CLEAR, '0);
		for (int i = 0; i < 8; i++) begin
			send_item(MODE_LOAD_FIRST, 32'd2 * i);
			send_item(MODE_LOAD_SECOND, 32'd3 * i);
		end
		// stop offering the last beat while the hold-off starts
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		for (int i = 0; i < 24; i++) begin
			send_item(MODE_PULL, '0);
			send_item(MODE_LOAD_FIRST, 32'd100 + i);
		end
	endtask

	// fill the first store past its depth; the flag must survive a clear
	task automatic test_store_overflow();
		logic [31:0] v1, v2;
		write_reg(REG_SET_OPERATION, OP_DIFFERENCE);
		send_item(MODE_CLEAR, '0);
		v1 = '0;
		v2 = '0;
		for (int i = 0; i < LIST_DEPTH + 3; i++) begin
			v1 = v1 + $urandom_range(1, 3);
			send_item(MODE_LOAD_FIRST, v1);
		end
		for (int i = 0; i < 10; i++) begin
			v2 = v2 + $urandom_range(1, 3);
			send_item(MODE_LOAD_SECOND, v2);
		end
		repeat (20) send_item(MODE_PULL, '0);
		write_reg(REG_SET_OPERATION, OP_COMPLEMENT);
		write_reg(REG_UNIVERSE_ROWS, 32'd5);
		send_item(MODE_CLEAR, '0);
		repeat (7) send_item(MODE_PULL, '0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 6;
		recv_idle_pct = 59;
		test_directed();
		test_random(6, 59, 35);
		test_random(59, 6, 35);
		test_random(0, 0, 35);
		test_backpressure();
		test_store_overflow();
		settle();
		$display("run covered %0d input beats and %0d result beats (%0d with an element)",
			beats_in, beats_out, elements_out);
		$display("over all set operations, reserved codes, long hold-off and store overflow");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/srsm_pkg.sv
hw/rtl/srsm_ctrl.sv
hw/rtl/srsm_dp.sv
hw/rtl/sorted_row_set_merge.sv
tb/tb.sv
